/* hw/rtl/ba_pkg.sv */
package ba_pkg;

	localparam int unsigned LEVELS_DEF = 8;
	localparam int unsigned HEAP_ORDER_RST = 16;
	localparam int unsigned MIN_ORDER_RST = 8;

	typedef enum logic [0:0] {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_ALLOC_ERR = 2'd1,
		ST_FREE_ERR  = 2'd2
	} status_t;

	typedef enum logic [0:0] {
		CFG_HEAP_ORDER = 1'b0,
		CFG_MIN_ORDER  = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic        opcode;
		logic [31:0] request_size;
		logic [30:0] free_offset;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [30:0] block_offset;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic init;     // load request/config derived registers
		logic clr;      // write clear pointer entry (root block at zero, else zero), step it
		logic rd_scan;  // read table at scan pointer
		logic scan_eval;
		logic rd_buddy;
		logic merge_eval;
		logic split_step;
		logic finish;
	} ba_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic pre_fail;   // request fails before touching the table
		logic is_free;
		logic scan_done;
		logic scan_hit;
		logic merge_more;
		logic split_done;
	} ba_sts_t;

endpackage

/* hw/rtl/ba_ram.sv */
module ba_ram #(
	parameter int unsigned WIDTH = 6,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hw/rtl/ba_ctrl.sv */
module ba_ctrl
	import ba_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_stall,
	output logic    rsp_valid,
	input  logic    rsp_stall,
	input  logic    cfg_wr,
	output logic    cfg_ready,
	output ba_cmd_t cmd,
	input  ba_sts_t sts
);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_DECIDE, S_SCAN_RD, S_SCAN_EV, S_SPLIT,
		S_FREE_RD, S_MERGE_RD, S_MERGE_EV, S_DONE, S_OUT
	} state_t;

	state_t state_q;

	assign req_stall = (state_q != S_IDLE);
	assign cfg_ready = ((state_q == S_IDLE) && !req_valid) || (state_q == S_CLEAR);
	assign rsp_valid = (state_q == S_OUT);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_CLEAR:    cmd.clr = 1'b1;
			S_IDLE:     cmd.init = req_valid;
			S_SCAN_RD:  cmd.rd_scan = 1'b1;
			S_SCAN_EV:  cmd.scan_eval = 1'b1;
			S_SPLIT:    cmd.split_step = 1'b1;
			S_FREE_RD,
			S_MERGE_RD: cmd.rd_buddy = 1'b1;
			S_MERGE_EV: cmd.merge_eval = 1'b1;
			S_DONE:     cmd.finish = 1'b1;
			default:    cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else if (cfg_wr) begin
			state_q <= S_CLEAR;
		end else begin
			unique case (state_q)
				S_CLEAR: if (sts.clr_done) state_q <= S_IDLE;
				S_IDLE: if (req_valid) state_q <= S_DECIDE;
				S_DECIDE: begin
					if (sts.pre_fail) state_q <= S_OUT;
					else if (sts.is_free) state_q <= S_FREE_RD;
					else state_q <= S_SCAN_RD;
				end
				S_SCAN_RD: state_q <= S_SCAN_EV;
				S_SCAN_EV: begin
					if (sts.scan_hit) state_q <= S_OUT;
					else if (sts.scan_done) state_q <= S_SPLIT;
					else state_q <= S_SCAN_RD;
				end
				S_SPLIT: if (sts.split_done) state_q <= S_OUT;
				S_FREE_RD: state_q <= S_MERGE_EV;
				S_MERGE_RD: state_q <= S_MERGE_EV;
				S_MERGE_EV: state_q <= sts.merge_more ? S_MERGE_RD : S_DONE;
				S_DONE: state_q <= S_OUT;
				S_OUT: if (!rsp_stall) state_q <= S_IDLE;
				default: state_q <= S_CLEAR;
			endcase
		end
	end

endmodule

/* hw/rtl/ba_dp.sv */
module ba_dp
	import ba_pkg::*;
#(
	parameter int unsigned LEVELS = LEVELS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cfg_wr,
	input  logic    cfg_index,
	input  logic [4:0] cfg_data,
	input  req_t    req,
	output rsp_t    rsp,
	input  ba_cmd_t cmd,
	output ba_sts_t sts
);

	localparam int unsigned AW = LEVELS;
	localparam int unsigned OW = $clog2(LEVELS + 1);

	logic [4:0] heap_order_q, min_order_q;
	logic [OW-1:0] lvl_q, k_q, ord_q, pick_ord_q;
	logic [AW:0] ptr_q;
	logic [AW-1:0] pick_q, u_q;
	logic found_q, pre_fail_q, is_free_q, first_q;
	rsp_t rsp_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [5:0] wdata, rdata;

	ba_ram #(.WIDTH(6), .DEPTH(2**AW)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	// request decode
	logic [5:0] diff6;
	logic [OW-1:0] lvl_c, k_c;
	logic [5:0] b_c, kd;
	logic small_c, pf_c;
	logic [31:0] sm1;
	logic [30:0] omask;
	logic [31:0] u32;

	always_comb begin
		small_c = heap_order_q < min_order_q;
		diff6 = {1'b0, heap_order_q} - {1'b0, min_order_q};
		if (small_c) lvl_c = '0;
		else if (diff6 > 6'(LEVELS)) lvl_c = OW'(LEVELS);
		else lvl_c = OW'(diff6);
		sm1 = req.request_size - 32'd1;
		b_c = '0;
		for (int i = 0; i < 32; i++) begin
			if (sm1[i]) b_c = 6'(i + 1);
		end
		kd = (b_c > {1'b0, min_order_q}) ? b_c - {1'b0, min_order_q} : 6'd0;
		k_c = (kd > 6'(LEVELS)) ? OW'(LEVELS) : OW'(kd);
		omask = 31'((64'd1 << min_order_q) - 64'd1);
		u32 = 32'({1'b0, req.free_offset} >> min_order_q);
		if (req.opcode == OP_FREE) begin
			pf_c = |(req.free_offset & omask) || (u32 >= (32'd1 << lvl_c));
		end else begin
			pf_c = (req.request_size == 32'd0) || small_c || (kd > 6'(lvl_c));
		end
	end

	logic [OW-1:0] e_ord, e_oc;
	assign e_ord = OW'(rdata[3:0]);
	assign e_oc = (e_ord > lvl_q) ? lvl_q : e_ord;

	logic [AW-1:0] buddy;
	assign buddy = u_q ^ AW'((AW+1)'(1) << ord_q);

	logic [AW:0] nxt_ptr;
	assign nxt_ptr = ptr_q + ((AW+1)'(1) << e_oc);

	logic [OW-1:0] sord;
	assign sord = pick_ord_q - OW'(1);

	logic hit_c, merge_ok;
	assign hit_c = !rdata[4] && (e_oc == k_q);
	assign merge_ok = rdata[5] && !rdata[4] && (e_ord == ord_q);

	always_comb begin
		we = 1'b0;
		waddr = u_q;
		wdata = '0;
		raddr = ptr_q[AW-1:0];
		if (cmd.clr) begin
			we = 1'b1;
			waddr = ptr_q[AW-1:0];
			wdata = (ptr_q == '0) ? {2'b10, 4'(lvl_c)} : 6'd0;
		end else if (cmd.scan_eval && hit_c) begin
			we = 1'b1;
			waddr = ptr_q[AW-1:0];
			wdata = {2'b11, 4'(k_q)};
		end else if (cmd.split_step && found_q) begin
			we = 1'b1;
			if (pick_ord_q > k_q) begin
				waddr = pick_q + AW'((AW+1)'(1) << sord);
				wdata = {2'b10, 4'(sord)};
			end else begin
				waddr = pick_q;
				wdata = {2'b11, 4'(k_q)};
			end
		end else if (cmd.merge_eval && first_q && !rdata[5]) begin
			we = 1'b0;
		end else if (cmd.merge_eval && !first_q && merge_ok && ord_q < lvl_q) begin
			we = 1'b1;
			waddr = (u_q < buddy) ? buddy : u_q;
			wdata = '0;
		end else if (cmd.finish && rsp_q.status == ST_OK) begin
			we = 1'b1;
			waddr = u_q;
			wdata = {2'b10, 4'(ord_q)};
		end
		if (cmd.rd_buddy) raddr = first_q ? u_q : buddy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_order_q <= 5'(HEAP_ORDER_RST);
			min_order_q <= 5'(MIN_ORDER_RST);
			ptr_q <= '0;
		end else begin
			if (cfg_wr) begin
				if (cfg_index == CFG_HEAP_ORDER) heap_order_q <= cfg_data;
				else min_order_q <= cfg_data;
				ptr_q <= '0;
			end else if (cmd.clr) begin
				ptr_q <= ptr_q + (AW+1)'(1);
			end else if (cmd.init) begin
				ptr_q <= '0;
			end else if (cmd.scan_eval) begin
				ptr_q <= nxt_ptr;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			lvl_q <= lvl_c;
		end
		if (cmd.init) begin
			k_q <= k_c;
			pre_fail_q <= pf_c;
			is_free_q <= (req.opcode == OP_FREE);
			found_q <= 1'b0;
			first_q <= 1'b1;
			u_q <= AW'(u32);
			rsp_q.status <= (req.opcode == OP_FREE) ? ST_FREE_ERR : ST_ALLOC_ERR;
			rsp_q.block_offset <= '0;
		end
		if (cmd.scan_eval) begin
			if (hit_c) begin
				rsp_q.status <= ST_OK;
				rsp_q.block_offset <= 31'(32'(ptr_q[AW-1:0]) << min_order_q);
			end else if (!rdata[4] && e_oc > k_q && !found_q) begin
				found_q <= 1'b1;
				pick_q <= ptr_q[AW-1:0];
				pick_ord_q <= e_ord;
			end
		end
		if (cmd.split_step && found_q) begin
			if (pick_ord_q > k_q) begin
				pick_ord_q <= sord;
			end else begin
				rsp_q.status <= ST_OK;
				rsp_q.block_offset <= 31'(32'(pick_q) << min_order_q);
			end
		end
		if (cmd.merge_eval) begin
			first_q <= 1'b0;
			if (first_q) begin
				ord_q <= e_ord;
				if (rdata[5]) rsp_q.status <= ST_OK;
			end else if (merge_ok && ord_q < lvl_q) begin
				u_q <= (u_q < buddy) ? u_q : buddy;
				ord_q <= ord_q + OW'(1);
			end
		end
	end

	always_comb begin
		sts.clr_done = ptr_q[AW-1:0] == '1;
		sts.pre_fail = pre_fail_q;
		sts.is_free = is_free_q;
		sts.scan_done = nxt_ptr >= ((AW+1)'(1) << lvl_q);
		sts.scan_hit = hit_c;
		sts.split_done = !found_q || (pick_ord_q <= k_q);
		if (first_q) sts.merge_more = rdata[5] && (e_ord < lvl_q);
		else sts.merge_more = merge_ok && (ord_q + OW'(1) < lvl_q);
		rsp = rsp_q;
	end

endmodule

/* hw/rtl/buddy_allocator.sv */
// allocate: a serial table scan, then a split pass when no block of the exact order is free
// free: one table read per merge level
// one request at a time; result held until taken
// reset and every configuration write start a clearing pass over the whole table
module buddy_allocator
	import ba_pkg::*;
#(
	parameter int unsigned LEVELS = LEVELS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  req_t       req,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output rsp_t       rsp,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [0:0] cfg_index,
	input  logic [4:0] cfg_data
);

	ba_cmd_t cmd;
	ba_sts_t sts;
	logic cfg_wr;

	assign cfg_wr = cfg_valid && cfg_ready;

	ba_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_stall(req_stall),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .cfg_wr(cfg_wr),
		.cfg_ready(cfg_ready), .cmd(cmd), .sts(sts)
	);

	ba_dp #(.LEVELS(LEVELS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_wr(cfg_wr), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req(req), .rsp(rsp), .cmd(cmd), .sts(sts)
	);

endmodule
